[design/bffra_pkg.sv]
// Shared types and constants for the bitmap first-fit run allocator.
// Holds the controller state and result enums and the command and status structs.
// No dependencies.
package bffra_pkg;

  // Default geometry of the sector map.
  localparam int MAP_SECTORS_DEF = 32768;
  localparam int DATA_BASE_DEF   = 18;
  localparam int MAX_RUN_DEF     = 2;

  // Fixed field widths of the request and result items.
  localparam int SECTOR_W = 15;
  localparam int COUNT_W  = 2;

  // The usage map is stored as words of this many sector bits.
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);

  // Request operation codes.
  localparam logic OP_REALLOC = 1'b0;
  localparam logic OP_FORMAT  = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_REL_RD,
    ST_REL_WR,
    ST_SCAN_START,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_FINISH
  } state_e;

  // Which result the output register takes.
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_FORMAT,
    RES_EMPTY,
    RES_FOUND
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_load;
    logic clr_init;
    logic clr_write;
    logic k_clr;
    logic k_inc;
    logic upd_rd;
    logic upd_wr;
    logic upd_set;
    logic scan_init;
    logic scan_next;
    logic hit_load;
    logic out_load;
    res_e res;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_op;
    logic req_reject;
    logic old_zero;
    logic new_zero;
    logic scan_off;
    logic rel_beyond;
    logic rel_k_last;
    logic mark_k_last;
    logic clr_last;
    logic scan_hit;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage

[design/bffra_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bffra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/bffra_ctrl.sv]
// Controller state machine of the run allocator.
// Sequences clearing, release, first-fit scan, marking and result hand-off.
// Depends on bffra_pkg.
module bffra_ctrl import bffra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   fmt_q, fmt_d;
  state_e ar_state;
  res_e   ar_res;

  // State, pending result kind and format flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      res_q   <= RES_FAIL;
      fmt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      fmt_q   <= fmt_d;
    end
  end

  // Where to go once the old run has been released.
  always_comb begin
    ar_res = res_q;
    if (sts_i.new_zero) begin
      ar_state = ST_FINISH;
      ar_res   = RES_EMPTY;
    end else if (sts_i.scan_off) begin
      ar_state = ST_FINISH;
      ar_res   = RES_FAIL;
    end else begin
      ar_state = ST_SCAN_START;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    fmt_d      = fmt_q;
    cmd_o      = '0;
    cmd_o.res  = res_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          if (fmt_q) begin
            state_d = ST_FINISH;
            res_d   = RES_FORMAT;
            fmt_d   = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.k_clr = 1'b1;
        priority if (sts_i.req_op == OP_FORMAT) begin
          cmd_o.clr_init = 1'b1;
          fmt_d          = 1'b1;
          state_d        = ST_CLEAR;
        end else if (sts_i.req_reject) begin
          res_d   = RES_FAIL;
          state_d = ST_FINISH;
        end else if (sts_i.old_zero) begin
          res_d   = ar_res;
          state_d = ar_state;
        end else begin
          state_d = ST_REL_RD;
        end
      end
      ST_REL_RD: begin
        if (sts_i.rel_beyond) begin
          // Sectors past the end of the map are skipped.
          cmd_o.k_inc = 1'b1;
          if (sts_i.rel_k_last) begin
            res_d   = ar_res;
            state_d = ar_state;
          end
        end else begin
          cmd_o.upd_rd = 1'b1;
          state_d      = ST_REL_WR;
        end
      end
      ST_REL_WR: begin
        cmd_o.upd_wr = 1'b1;
        cmd_o.k_inc  = 1'b1;
        if (sts_i.rel_k_last) begin
          res_d   = ar_res;
          state_d = ar_state;
        end else begin
          state_d = ST_REL_RD;
        end
      end
      ST_SCAN_START: begin
        cmd_o.scan_init = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (sts_i.scan_hit) begin
          cmd_o.hit_load = 1'b1;
          cmd_o.k_clr    = 1'b1;
          state_d        = ST_MARK_RD;
        end else if (sts_i.scan_last) begin
          res_d   = RES_FAIL;
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_MARK_RD: begin
        cmd_o.upd_rd  = 1'b1;
        cmd_o.upd_set = 1'b1;
        state_d       = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        cmd_o.upd_wr  = 1'b1;
        cmd_o.upd_set = 1'b1;
        cmd_o.k_inc   = 1'b1;
        if (sts_i.mark_k_last) begin
          res_d   = RES_FOUND;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_MARK_RD;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A found run is marked starting right after the hit.
  a_hit_then_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.hit_load |=> cmd_o.upd_rd && cmd_o.upd_set)
    else $error("hit not followed by a mark read");

  // The output register is loaded only when its last result has gone.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded over a pending one");

  // Every map write of a run update follows the read of the same word.
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_wr |-> $past(cmd_o.upd_rd) && (cmd_o.upd_set == $past(cmd_o.upd_set)))
    else $error("map write without preceding read");

endmodule

[design/bffra_dp.sv]
// Datapath of the run allocator: usage map RAM, request registers, scan logic.
// Scans one map word per cycle and updates single sectors by read-modify-write.
// Depends on bffra_pkg and bffra_ram.
module bffra_dp import bffra_pkg::*; #(
  parameter int MAP_SECTORS = MAP_SECTORS_DEF,
  parameter int DATA_BASE   = DATA_BASE_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                op_i,
  input  logic [SECTOR_W-1:0] old_first_i,
  input  logic [COUNT_W-1:0]  old_count_i,
  input  logic [COUNT_W-1:0]  new_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                ok_o,
  output logic [SECTOR_W-1:0] run_start_o
);

  localparam int DEPTH  = (MAP_SECTORS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SEC_W  =
    (($clog2(MAP_SECTORS) > SECTOR_W) ? $clog2(MAP_SECTORS) : SECTOR_W) + 1;
  localparam bit NO_SEARCH  = (DATA_BASE >= MAP_SECTORS);
  localparam int START_WORD = NO_SEARCH ? 0 : DATA_BASE / WORD_W;
  localparam int FULL_WORDS = DATA_BASE / WORD_W;
  localparam int LO_BITS    = DATA_BASE % WORD_W;
  localparam int HI_BITS    = MAP_SECTORS % WORD_W;
  localparam logic [WORD_W-1:0] LO_MASK = WORD_W'((64'd1 << LO_BITS) - 64'd1);
  localparam logic [WORD_W-1:0] HI_MASK =
    (HI_BITS == 0) ? '0 : ~WORD_W'((64'd1 << HI_BITS) - 64'd1);
  localparam logic [SECTOR_W-1:0] EMPTY_FIRST =
    (DATA_BASE <= MAP_SECTORS) ? SECTOR_W'(DATA_BASE) : '0;
  localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'(START_WORD);

  // Request registers.
  logic                op_q;
  logic [SECTOR_W-1:0] old_first_q;
  logic [COUNT_W-1:0]  old_count_q;
  logic [COUNT_W-1:0]  new_count_q;

  // Sequencing registers.
  logic [ADDR_W-1:0]   clr_q;
  logic [COUNT_W-1:0]  k_q;
  logic [ADDR_W-1:0]   word_q;
  logic [MAX_RUN-1:0]  prev_free_q;
  logic [SEC_W-1:0]    run_first_q;

  // Output register.
  logic                out_valid_q;
  logic                out_ok_q;
  logic [SECTOR_W-1:0] out_first_q;

  // RAM ports and scan logic.
  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [WORD_W-1:0]         wdata;
  logic [ADDR_W-1:0]         raddr;
  logic [WORD_W-1:0]         rdata;
  logic [SEC_W-1:0]          sector;
  logic [SEC_W-1:0]          rel_sector;
  logic [WORD_W-1:0]         bit_mask;
  logic [WORD_W-1:0]         clr_word;
  logic [WORD_W-1:0]         free_w;
  logic [WORD_W+MAX_RUN-1:0] ext;
  logic [WORD_W-1:0]         hit_vec;
  logic [BIT_W-1:0]          hit_idx;
  logic [SEC_W-1:0]          hit_end;

  bffra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Capture the request on transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q        <= op_i;
      old_first_q <= old_first_i;
      old_count_q <= old_count_i;
      new_count_q <= new_count_i;
    end
  end

  // Sector addressed by a release or a mark step.
  assign rel_sector = SEC_W'(old_first_q) + SEC_W'(k_q);
  assign sector     = cmd_i.upd_set ? (run_first_q + SEC_W'(k_q)) : rel_sector;
  assign bit_mask   = WORD_W'(1) << sector[BIT_W-1:0];

  // Reset contents of the word under the clearing counter.
  always_comb begin
    if (32'(clr_q) < 32'(FULL_WORDS)) begin
      clr_word = '1;
    end else if (32'(clr_q) == 32'(FULL_WORDS)) begin
      clr_word = LO_MASK;
    end else begin
      clr_word = '0;
    end
  end

  // Map write and read port muxing.
  always_comb begin
    we    = cmd_i.clr_write || cmd_i.upd_wr;
    waddr = cmd_i.clr_write ? clr_q : sector[ADDR_W+BIT_W-1:BIT_W];
    if (cmd_i.clr_write) begin
      wdata = clr_word;
    end else if (cmd_i.upd_set) begin
      wdata = rdata | bit_mask;
    end else begin
      wdata = rdata & ~bit_mask;
    end
    priority if (cmd_i.upd_rd) begin
      raddr = sector[ADDR_W+BIT_W-1:BIT_W];
    end else if (cmd_i.scan_init) begin
      raddr = START_ADDR;
    end else begin
      raddr = word_q + ADDR_W'(1);
    end
  end

  // Free bits of the scanned word, with sectors outside the data area taken as used.
  always_comb begin
    free_w = ~(rdata | ((word_q == START_ADDR) ? LO_MASK : '0)
                     | ((word_q == LAST_WORD) ? HI_MASK : '0));
    ext    = {free_w, prev_free_q};
  end

  // A run ends at bit i when the new_count bits ending there are all free.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      hit_vec[i] = 1'b1;
      for (int j = 0; j < MAX_RUN; j++) begin
        if (j < int'(new_count_q)) begin
          hit_vec[i] = hit_vec[i] & ext[i + MAX_RUN - j];
        end
      end
    end
    hit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = BIT_W'(i);
      end
    end
    hit_end = SEC_W'({word_q, hit_idx});
  end

  // Clearing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Run step counter, scan position and found run.
  always_ff @(posedge clk_i) begin
    if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + COUNT_W'(1);
    end
    if (cmd_i.scan_init) begin
      word_q      <= START_ADDR;
      prev_free_q <= '0;
    end else if (cmd_i.scan_next) begin
      word_q      <= word_q + ADDR_W'(1);
      prev_free_q <= free_w[WORD_W-1 -: MAX_RUN];
    end
    if (cmd_i.hit_load) begin
      run_first_q <= hit_end + SEC_W'(1) - SEC_W'(new_count_q);
    end
  end

  // Output register: holds one result until the downstream transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.res)
        RES_FAIL: begin
          out_ok_q    <= 1'b0;
          out_first_q <= '0;
        end
        RES_FORMAT: begin
          out_ok_q    <= 1'b1;
          out_first_q <= '0;
        end
        RES_EMPTY: begin
          out_ok_q    <= 1'b1;
          out_first_q <= EMPTY_FIRST;
        end
        RES_FOUND: begin
          out_ok_q    <= 1'b1;
          out_first_q <= run_first_q[SECTOR_W-1:0];
        end
        default: begin
          out_ok_q    <= 1'b0;
          out_first_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign run_start_o = out_first_q;

  // Status to the controller.
  always_comb begin
    sts_o.req_op      = op_q;
    sts_o.req_reject  = (32'(old_count_q) > 32'(MAX_RUN)) ||
                        (32'(new_count_q) > 32'(MAX_RUN));
    sts_o.old_zero    = (old_count_q == '0);
    sts_o.new_zero    = (new_count_q == '0);
    sts_o.scan_off    = NO_SEARCH;
    sts_o.rel_beyond  = (rel_sector >= SEC_W'(MAP_SECTORS));
    sts_o.rel_k_last  = (({1'b0, k_q} + (COUNT_W+1)'(1)) == {1'b0, old_count_q});
    sts_o.mark_k_last = (({1'b0, k_q} + (COUNT_W+1)'(1)) == {1'b0, new_count_q});
    sts_o.clr_last    = (clr_q == LAST_WORD);
    sts_o.scan_hit    = |hit_vec;
    sts_o.scan_last   = (word_q == LAST_WORD);
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

  // Clearing pass and run updates never share the write port.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_write && cmd_i.upd_wr))
    else $error("two writers on the map port");

  // A marked sector always lies inside the map.
  a_mark_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd_wr && cmd_i.upd_set) |-> (sector < SEC_W'(MAP_SECTORS)))
    else $error("mark outside the map");

  // The scan never steps past the last map word.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_next |-> (word_q != LAST_WORD))
    else $error("scan ran past the map");

endmodule

[design/bitmap_first_fit_run_allocator_core.sv]
// Bitmap first-fit run allocator: one request in, one result out.
// The usage map is scanned one word per cycle from the data start (32 sectors per word);
// a released sector past the map is skipped. One request is in work at a time.
// After reset and on format the map is rewritten one word a cycle (MAP_SECTORS/32 rounded up,
// 1024 by default) while the input is stalled; the result register frees the input side.
module bitmap_first_fit_run_allocator_core import bffra_pkg::*; #(
  parameter int MAP_SECTORS = MAP_SECTORS_DEF,
  parameter int DATA_BASE   = DATA_BASE_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [SECTOR_W-1:0] old_first_i,
  input  logic [COUNT_W-1:0]  old_count_i,
  input  logic [COUNT_W-1:0]  new_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                ok_o,
  output logic [SECTOR_W-1:0] run_start_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller.
  bffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Datapath with the usage map.
  bffra_dp #(
    .MAP_SECTORS (MAP_SECTORS),
    .DATA_BASE   (DATA_BASE),
    .MAX_RUN     (MAX_RUN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (op_i),
    .old_first_i (old_first_i),
    .old_count_i (old_count_i),
    .new_count_i (new_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .run_start_o (run_start_o)
  );

endmodule
